>>> src/ssp_pkg.sv
// ssp_pkg: shared types, constants and codes for the shortest path block.
// No dependencies; used by ssp_ctrl, ssp_datapath and single_source_shortest_path.

package ssp_pkg;

   localparam int NODE_COUNT_DEF  = 16;
   localparam int WEIGHT_BITS_DEF = 8;

   localparam int NODE_ID_BITS = 4;
   localparam int DIST_BITS    = 16;
   localparam int OUT_CAP      = 16;

   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
   localparam logic [DIST_BITS:0]   DIST_INF = {1'b1, {DIST_BITS{1'b0}}};

   localparam logic FUNC_ADD_EDGE = 1'b0;
   localparam logic FUNC_QUERY    = 1'b1;

   typedef struct packed {
      logic                    func;
      logic [NODE_ID_BITS-1:0] end_a;
      logic [NODE_ID_BITS-1:0] end_b;
      logic [7:0]              edge_weight;
      logic [NODE_ID_BITS-1:0] source_node;
   } req_type;

   typedef struct packed {
      logic [NODE_ID_BITS-1:0] node_index;
      logic [DIST_BITS-1:0]    distance;
      logic                    reachable;
      logic                    last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EDGE_RD,
      S_EDGE_WR_AB,
      S_EDGE_WR_BA,
      S_INIT,
      S_ROUND,
      S_SCAN,
      S_SCAN_END,
      S_PICK,
      S_RELAX,
      S_RELAX_END,
      S_OUT_RD,
      S_OUT_LD,
      S_OUT_WAIT
   } ssp_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_EDGE_RD,
      OP_EDGE_WR_AB,
      OP_EDGE_WR_BA,
      OP_INIT,
      OP_ROUND,
      OP_SCAN,
      OP_PICK,
      OP_RELAX,
      OP_OUT_RD,
      OP_OUT_LD,
      OP_OUT_NEXT
   } ssp_op_type;

   typedef struct packed {
      ssp_op_type op;
      logic       take;
   } ssp_cmd_type;

   typedef struct packed {
      logic req_query;
      logic req_edge_ok;
      logic clr_last;
      logic cnt_last;
      logic have;
      logic best_inf;
      logic rounds_done;
      logic out_last;
      logic rsp_taken;
   } ssp_sts_type;

endpackage

>>> src/ssp_ctrl.sv
// ssp_ctrl: sequencer for clearing, edge updates, Dijkstra rounds and result output.
// Depends on ssp_pkg; drives ssp_datapath through ssp_cmd_type commands.

module ssp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ssp_pkg::ssp_sts_type sts,
   output ssp_pkg::ssp_cmd_type cmd
);

   ssp_pkg::ssp_state_type state_ff;
   ssp_pkg::ssp_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssp_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssp_pkg::S_CLEAR: begin
            if (sts.clr_last) state_in = ssp_pkg::S_IDLE;
         end
         ssp_pkg::S_IDLE: begin
            if (req_valid) begin
               if (sts.req_query) state_in = ssp_pkg::S_INIT;
               else if (sts.req_edge_ok) state_in = ssp_pkg::S_EDGE_RD;
            end
         end
         ssp_pkg::S_EDGE_RD:    state_in = ssp_pkg::S_EDGE_WR_AB;
         ssp_pkg::S_EDGE_WR_AB: state_in = ssp_pkg::S_EDGE_WR_BA;
         ssp_pkg::S_EDGE_WR_BA: state_in = ssp_pkg::S_IDLE;
         ssp_pkg::S_INIT:       state_in = ssp_pkg::S_ROUND;
         ssp_pkg::S_ROUND: begin
            state_in = sts.rounds_done ? ssp_pkg::S_OUT_RD : ssp_pkg::S_SCAN;
         end
         ssp_pkg::S_SCAN: begin
            if (sts.cnt_last) state_in = ssp_pkg::S_SCAN_END;
         end
         ssp_pkg::S_SCAN_END:   state_in = ssp_pkg::S_PICK;
         ssp_pkg::S_PICK: begin
            // no unfinished node left: done early
            if (!sts.have) state_in = ssp_pkg::S_OUT_RD;
            else if (sts.best_inf) state_in = ssp_pkg::S_ROUND;
            else state_in = ssp_pkg::S_RELAX;
         end
         ssp_pkg::S_RELAX: begin
            if (sts.cnt_last) state_in = ssp_pkg::S_RELAX_END;
         end
         ssp_pkg::S_RELAX_END:  state_in = ssp_pkg::S_ROUND;
         ssp_pkg::S_OUT_RD:     state_in = ssp_pkg::S_OUT_LD;
         ssp_pkg::S_OUT_LD:     state_in = ssp_pkg::S_OUT_WAIT;
         ssp_pkg::S_OUT_WAIT: begin
            if (sts.rsp_taken) begin
               state_in = sts.out_last ? ssp_pkg::S_IDLE : ssp_pkg::S_OUT_RD;
            end
         end
         default:               state_in = ssp_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op    = ssp_pkg::OP_NONE;
      cmd.take  = 1'b0;
      req_stall = 1'b1;
      case (state_ff)
         ssp_pkg::S_CLEAR:      cmd.op = ssp_pkg::OP_CLEAR;
         ssp_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.take  = req_valid;
         end
         ssp_pkg::S_EDGE_RD:    cmd.op = ssp_pkg::OP_EDGE_RD;
         ssp_pkg::S_EDGE_WR_AB: cmd.op = ssp_pkg::OP_EDGE_WR_AB;
         ssp_pkg::S_EDGE_WR_BA: cmd.op = ssp_pkg::OP_EDGE_WR_BA;
         ssp_pkg::S_INIT:       cmd.op = ssp_pkg::OP_INIT;
         ssp_pkg::S_ROUND:      cmd.op = ssp_pkg::OP_ROUND;
         ssp_pkg::S_SCAN:       cmd.op = ssp_pkg::OP_SCAN;
         ssp_pkg::S_PICK:       cmd.op = ssp_pkg::OP_PICK;
         ssp_pkg::S_RELAX:      cmd.op = ssp_pkg::OP_RELAX;
         ssp_pkg::S_OUT_RD:     cmd.op = ssp_pkg::OP_OUT_RD;
         ssp_pkg::S_OUT_LD:     cmd.op = ssp_pkg::OP_OUT_LD;
         ssp_pkg::S_OUT_WAIT: begin
            if (sts.rsp_taken) cmd.op = ssp_pkg::OP_OUT_NEXT;
         end
         default:               cmd.op = ssp_pkg::OP_NONE;
      endcase
   end

endmodule

>>> src/ssp_datapath.sv
// ssp_datapath: weight matrix memory, distance memory, done/valid flags,
// min scan, relax adder and result register. Depends on ssp_pkg; run by ssp_ctrl.

module ssp_datapath #(
   parameter int NODE_COUNT  = ssp_pkg::NODE_COUNT_DEF,
   parameter int WEIGHT_BITS = ssp_pkg::WEIGHT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ssp_pkg::req_type     req_data,
   input  ssp_pkg::ssp_cmd_type cmd,
   output ssp_pkg::ssp_sts_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ssp_pkg::rsp_type     rsp_data
);

   localparam int NB        = $clog2(NODE_COUNT);
   localparam int RB        = $clog2(NODE_COUNT + 1);
   localparam int AB        = 2 * NB;
   localparam int ADJ_DEPTH = 1 << AB;
   localparam int DB        = ssp_pkg::DIST_BITS;
   localparam int RES       = (NODE_COUNT < ssp_pkg::OUT_CAP) ? NODE_COUNT : ssp_pkg::OUT_CAP;

   ssp_pkg::req_type req_ff;

   logic [NB-1:0]         cnt_ff, cnt_in;
   logic [AB-1:0]         clr_ff, clr_in;
   logic [RB-1:0]         round_ff, round_in;
   logic                  have_ff, have_in;
   logic [DB:0]           best_ff;
   logic [NB-1:0]         pick_ff;
   logic [NODE_COUNT-1:0] done_ff, done_in;
   logic [NODE_COUNT-1:0] vld_ff, vld_in;
   logic                  tag_scan_ff, tag_relax_ff;
   logic [NB-1:0]         jd_ff;

   logic [WEIGHT_BITS:0]  adj_mem [ADJ_DEPTH];
   logic [WEIGHT_BITS:0]  adj_q;
   logic [DB-1:0]         dist_mem [NODE_COUNT];
   logic [DB-1:0]         dist_q;

   logic                  rsp_valid_ff, rsp_valid_in;
   ssp_pkg::rsp_type      rsp_data_ff;

   logic [NB-1:0]          a_idx, b_idx, src_idx;
   logic [WEIGHT_BITS-1:0] w_val;
   logic                   src_ok, adj_upd, rsp_taken;
   logic [DB:0]            eff_j, sum_wide;
   logic [DB-1:0]          sum_sat;
   logic                   scan_hit, relax_hit;

   logic                   adj_rd_en, adj_wr_en;
   logic [AB-1:0]          adj_rd_addr, adj_wr_addr;
   logic [WEIGHT_BITS:0]   adj_wr_data;
   logic                   dist_rd_en, dist_wr_en;
   logic [NB-1:0]          dist_wr_addr;
   logic [DB-1:0]          dist_wr_data;

   assign a_idx   = NB'(req_ff.end_a);
   assign b_idx   = NB'(req_ff.end_b);
   assign src_idx = NB'(req_ff.source_node);
   assign w_val   = WEIGHT_BITS'(req_ff.edge_weight);
   assign src_ok  = int'(req_ff.source_node) < NODE_COUNT;

   // parallel edges keep the smaller weight
   assign adj_upd = !adj_q[WEIGHT_BITS] || (w_val < adj_q[WEIGHT_BITS-1:0]);

   // a node without a written distance this query reads as infinity
   assign eff_j    = vld_ff[jd_ff] ? {1'b0, dist_q} : ssp_pkg::DIST_INF;
   assign sum_wide = {1'b0, best_ff[DB-1:0]} + (DB+1)'(adj_q[WEIGHT_BITS-1:0]);
   assign sum_sat  = sum_wide[DB] ? ssp_pkg::DIST_MAX : sum_wide[DB-1:0];

   assign scan_hit  = tag_scan_ff && !done_ff[jd_ff] && (!have_ff || (eff_j < best_ff));
   assign relax_hit = tag_relax_ff && !done_ff[jd_ff] && adj_q[WEIGHT_BITS]
                      && ({1'b0, sum_sat} < eff_j);

   assign rsp_taken = rsp_valid_ff && !rsp_stall;

   // weight matrix port control
   always_comb begin
      adj_rd_en   = 1'b0;
      adj_rd_addr = {a_idx, b_idx};
      adj_wr_en   = 1'b0;
      adj_wr_addr = clr_ff;
      adj_wr_data = '0;
      case (cmd.op)
         ssp_pkg::OP_CLEAR: begin
            adj_wr_en = 1'b1;
         end
         ssp_pkg::OP_EDGE_RD: begin
            adj_rd_en = 1'b1;
         end
         ssp_pkg::OP_EDGE_WR_AB: begin
            adj_wr_en   = adj_upd;
            adj_wr_addr = {a_idx, b_idx};
            adj_wr_data = {1'b1, w_val};
         end
         ssp_pkg::OP_EDGE_WR_BA: begin
            adj_wr_en   = adj_upd;
            adj_wr_addr = {b_idx, a_idx};
            adj_wr_data = {1'b1, w_val};
         end
         ssp_pkg::OP_RELAX: begin
            adj_rd_en   = 1'b1;
            adj_rd_addr = {pick_ff, cnt_ff};
         end
         default: begin
            adj_rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adj_wr_en) adj_mem[adj_wr_addr] <= adj_wr_data;
   end

   always_ff @(posedge clock) begin
      if (adj_rd_en) adj_q <= adj_mem[adj_rd_addr];
   end

   // distance memory port control
   always_comb begin
      dist_rd_en   = (cmd.op == ssp_pkg::OP_SCAN) || (cmd.op == ssp_pkg::OP_RELAX)
                     || (cmd.op == ssp_pkg::OP_OUT_RD);
      dist_wr_en   = 1'b0;
      dist_wr_addr = jd_ff;
      dist_wr_data = sum_sat;
      if (cmd.op == ssp_pkg::OP_INIT) begin
         dist_wr_en   = src_ok;
         dist_wr_addr = src_idx;
         dist_wr_data = '0;
      end else if (relax_hit) begin
         dist_wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (dist_wr_en) dist_mem[dist_wr_addr] <= dist_wr_data;
   end

   always_ff @(posedge clock) begin
      if (dist_rd_en) dist_q <= dist_mem[cnt_ff];
   end

   // counters and flags
   always_comb begin
      cnt_in   = cnt_ff;
      clr_in   = clr_ff;
      round_in = round_ff;
      have_in  = have_ff;
      done_in  = done_ff;
      vld_in   = vld_ff;
      case (cmd.op)
         ssp_pkg::OP_CLEAR: clr_in = clr_ff + 1'b1;
         ssp_pkg::OP_INIT: begin
            round_in = '0;
            done_in  = '0;
            vld_in   = '0;
            if (src_ok) vld_in[src_idx] = 1'b1;
         end
         ssp_pkg::OP_ROUND: begin
            cnt_in  = '0;
            have_in = 1'b0;
         end
         ssp_pkg::OP_PICK: begin
            cnt_in = '0;
            if (have_ff) begin
               done_in[pick_ff] = 1'b1;
               round_in         = round_ff + 1'b1;
            end
         end
         ssp_pkg::OP_SCAN, ssp_pkg::OP_RELAX, ssp_pkg::OP_OUT_NEXT: begin
            cnt_in = cnt_ff + 1'b1;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
      if (scan_hit) have_in = 1'b1;
      if (relax_hit) vld_in[jd_ff] = 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_taken) rsp_valid_in = 1'b0;
      if (cmd.op == ssp_pkg::OP_OUT_LD) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         clr_ff       <= '0;
         round_ff     <= '0;
         have_ff      <= 1'b0;
         done_ff      <= '0;
         vld_ff       <= '0;
         tag_scan_ff  <= 1'b0;
         tag_relax_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         round_ff     <= round_in;
         have_ff      <= have_in;
         done_ff      <= done_in;
         vld_ff       <= vld_in;
         tag_scan_ff  <= (cmd.op == ssp_pkg::OP_SCAN);
         tag_relax_ff <= (cmd.op == ssp_pkg::OP_RELAX);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      jd_ff <= cnt_ff;
      if (cmd.take) req_ff <= req_data;
      if (scan_hit) begin
         best_ff <= eff_j;
         pick_ff <= jd_ff;
      end
      if (cmd.op == ssp_pkg::OP_OUT_LD) begin
         rsp_data_ff.node_index <= ssp_pkg::NODE_ID_BITS'(cnt_ff);
         rsp_data_ff.reachable  <= vld_ff[cnt_ff];
         rsp_data_ff.distance   <= vld_ff[cnt_ff] ? dist_q : '0;
         rsp_data_ff.last       <= (cnt_ff == NB'(RES - 1));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign sts.req_query   = (req_data.func == ssp_pkg::FUNC_QUERY);
   assign sts.req_edge_ok = (int'(req_data.end_a) < NODE_COUNT)
                            && (int'(req_data.end_b) < NODE_COUNT);
   assign sts.clr_last    = &clr_ff;
   assign sts.cnt_last    = (cnt_ff == NB'(NODE_COUNT - 1));
   assign sts.have        = have_ff;
   assign sts.best_inf    = best_ff[DB];
   assign sts.rounds_done = (round_ff == RB'(NODE_COUNT));
   assign sts.out_last    = (cnt_ff == NB'(RES - 1));
   assign sts.rsp_taken   = rsp_taken;

endmodule

>>> src/single_source_shortest_path.sv
// single_source_shortest_path: top level, dense Dijkstra over a stored weight matrix.
// Depends on ssp_pkg, ssp_ctrl and ssp_datapath.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------------
//   request | req_valid, req_stall, req_data | add-edge or query command
//   result  | rsp_valid, rsp_stall, rsp_data | one node distance per transfer
//
// After reset the weight matrix is cleared, one entry a cycle, all 2**(2*clog2(NODE_COUNT))
// entries (256 at 16 nodes); no request is taken until it ends.
// An edge add runs as transfer, read, then the two compare-gated symmetric writes.
// A query runs up to NODE_COUNT rounds, each a scan of the distance memory and, when the
// picked node is at a finite distance, a relax pass over one matrix row; then the results
// leave one at a time through the output register, held while rsp_stall is high.
// The single read port of each memory sets the one-node-per-cycle scan and relax pace.

module single_source_shortest_path #(
   parameter int NODE_COUNT  = ssp_pkg::NODE_COUNT_DEF,
   parameter int WEIGHT_BITS = ssp_pkg::WEIGHT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ssp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ssp_pkg::rsp_type rsp_data
);

   ssp_pkg::ssp_cmd_type cmd;
   ssp_pkg::ssp_sts_type sts;

   ssp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ssp_datapath #(
      .NODE_COUNT  (NODE_COUNT),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for single_source_shortest_path (edge adds and Dijkstra queries).
// Depends on ssp_pkg and the RTL only; predicts every node result and compares in order.

module tb;

   localparam int NODES       = 16;
   localparam int HALF_PERIOD = 6;
   localparam int HOLD_CYCLES = 1500;
   localparam int SETTLE      = 40;
   localparam int TIMEOUT_NS  = 12_000_000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ssp_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ssp_pkg::rsp_type rsp_data;

   // stored graph and per-query scratch of the predictor
   logic             wt_valid [NODES][NODES];
   logic [7:0]       wt_value [NODES][NODES];
   logic [16:0]      dist_now [NODES];
   logic             done_now [NODES];
   ssp_pkg::rsp_type dist_expect_q[$];

   int   errors         = 0;
   int   items_sent     = 0;
   int   queries_sent   = 0;
   int   results_seen   = 0;
   logic steady         = 1'b0;
   int   hold_req_count = 0;
   int   hold_seen      = 0;
   int   hold_left      = 0;

   always #HALF_PERIOD clock = ~clock;

   single_source_shortest_path i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // ---------------- predictor ----------------

   task automatic store_weight(int a, int b, logic [7:0] w);
      if (!wt_valid[a][b] || w < wt_value[a][b]) begin
         wt_valid[a][b] = 1'b1;
         wt_value[a][b] = w;
      end
   endtask

   task automatic predict_distances(logic [3:0] src);
      int               pick;
      bit               have;
      logic [16:0]      sum;
      ssp_pkg::rsp_type r;
      for (int i = 0; i < NODES; i++) begin
         dist_now[i] = ssp_pkg::DIST_INF;
         done_now[i] = 1'b0;
      end
      dist_now[src] = '0;
      for (int round = 0; round < NODES; round++) begin
         have = 0;
         pick = 0;
         for (int j = 0; j < NODES; j++) begin
            if (!done_now[j] && (!have || dist_now[j] < dist_now[pick])) begin
               pick = j;
               have = 1;
            end
         end
         if (!have) break;
         done_now[pick] = 1'b1;
         // an infinite node relaxes nothing
         if (dist_now[pick] < ssp_pkg::DIST_INF) begin
            for (int j = 0; j < NODES; j++) begin
               if (!done_now[j] && wt_valid[pick][j]) begin
                  sum = dist_now[pick] + 17'(wt_value[pick][j]);
                  if (sum > 17'(ssp_pkg::DIST_MAX)) sum = 17'(ssp_pkg::DIST_MAX);
                  if (sum < dist_now[j]) dist_now[j] = sum;
               end
            end
         end
      end
      for (int i = 0; i < NODES; i++) begin
         r.node_index = 4'(i);
         r.reachable  = dist_now[i] < ssp_pkg::DIST_INF;
         r.distance   = r.reachable ? dist_now[i][15:0] : '0;
         r.last       = (i == NODES - 1);
         dist_expect_q = {dist_expect_q, r};
      end
   endtask

   task automatic predict_item(ssp_pkg::req_type it);
      if (it.func == ssp_pkg::FUNC_ADD_EDGE) begin
         store_weight(it.end_a, it.end_b, it.edge_weight);
         store_weight(it.end_b, it.end_a, it.edge_weight);
      end else begin
         predict_distances(it.source_node);
      end
   endtask

   // ---------------- item builders ----------------

   function automatic ssp_pkg::req_type edge_item(int a, int b, int w);
      ssp_pkg::req_type it;
      it.func        = ssp_pkg::FUNC_ADD_EDGE;
      it.end_a       = 4'(a);
      it.end_b       = 4'(b);
      it.edge_weight = 8'(w);
      it.source_node = 4'($urandom_range(15));
      return it;
   endfunction

   function automatic ssp_pkg::req_type query_item(int src);
      ssp_pkg::req_type it;
      it.func        = ssp_pkg::FUNC_QUERY;
      it.end_a       = 4'($urandom_range(15));
      it.end_b       = 4'($urandom_range(15));
      it.edge_weight = 8'($urandom_range(255));
      it.source_node = 4'(src);
      return it;
   endfunction

   // ---------------- request side ----------------

   // valid stays high after a transfer; a drain, or a random gap in the next call, lowers it
   task automatic send_item(ssp_pkg::req_type it);
      if (!steady) begin
         while ($urandom_range(99) < 15) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(it);
      items_sent++;
      if (it.func == ssp_pkg::FUNC_QUERY) queries_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (dist_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // ---------------- result side ----------------

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_req_count) begin
         hold_seen <= hold_req_count;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 15);
      end
   end

   always @(posedge clock) begin : check_results
      ssp_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (dist_expect_q.size() == 0) begin
            $error("unexpected result transfer: node_index %0d", rsp_data.node_index);
            errors++;
         end else begin
            want = dist_expect_q.pop_front();
            if (rsp_data.node_index !== want.node_index) begin
               $error("node_index expected %0d actual %0d", want.node_index,
                      rsp_data.node_index);
               errors++;
            end
            if (rsp_data.distance !== want.distance) begin
               $error("distance expected %0d actual %0d (node %0d)", want.distance,
                      rsp_data.distance, want.node_index);
               errors++;
            end
            if (rsp_data.reachable !== want.reachable) begin
               $error("reachable expected %0d actual %0d (node %0d)", want.reachable,
                      rsp_data.reachable, want.node_index);
               errors++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last expected %0d actual %0d (node %0d)", want.last,
                      rsp_data.last, want.node_index);
               errors++;
            end
         end
      end
   end

   // ---------------- tests ----------------

   task automatic test_empty_graph();
      send_item(query_item(0));
      send_item(query_item(15));
   endtask

   task automatic test_edge_rules();
      send_item(edge_item(0, 1, 255));
      send_item(edge_item(1, 2, 0));
      send_item(edge_item(2, 2, 17));    // self loop
      send_item(edge_item(1, 0, 200));   // parallel, lower weight wins
      send_item(edge_item(0, 1, 250));   // parallel, higher weight dropped
      send_item(edge_item(15, 14, 1));
      send_item(edge_item(14, 13, 128));
      send_item(query_item(0));
      send_item(query_item(2));
      send_item(query_item(13));
      send_item(edge_item(2, 15, 3));    // joins the two components
      send_item(query_item(15));
      send_item(query_item(7));          // isolated source
   endtask

   task automatic test_backpressure();
      drain_results();
      hold_req_count <= hold_req_count + 1;
      send_item(query_item(1));
      send_item(edge_item(3, 4, 9));
      send_item(edge_item(4, 5, 250));
      send_item(query_item(4));
      send_item(edge_item(5, 6, 77));
      drain_results();                   // sender waits for every result
   endtask

   task automatic test_random(int count);
      int               pick;
      int               a;
      int               b;
      int               w;
      ssp_pkg::req_type prev;
      prev = edge_item(0, 1, 255);
      for (int k = 0; k < count; k++) begin
         if (k == count / 3) steady <= 1'b1;
         if (k == 2 * count / 3) steady <= 1'b0;
         pick = $urandom_range(99);
         a    = $urandom_range(15);
         b    = $urandom_range(15);
         case ($urandom_range(9))
            0:       w = 0;
            1:       w = 255;
            2, 3:    w = $urandom_range(15);
            default: w = $urandom_range(255);
         endcase
         if (pick < 25) begin
            send_item(query_item($urandom_range(15)));
         end else if (pick < 35) begin
            prev = edge_item(prev.end_b, prev.end_a, w);
            send_item(prev);
         end else if (pick < 40) begin
            send_item(edge_item(a, a, w));
         end else begin
            prev = edge_item(a, b, w);
            send_item(prev);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < NODES; i++) begin
         for (int j = 0; j < NODES; j++) begin
            wt_valid[i][j] = 1'b0;
            wt_value[i][j] = '0;
         end
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_graph();
      test_edge_rules();
      test_backpressure();
      test_random(92);
      drain_results();

      $display("Covered %0d requests (%0d queries), %0d node results, a long output hold.",
               items_sent, queries_sent, results_seen);
      $display("Directed: empty graph, zero/max weights, self loop, parallel edges, isolated node.");
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $error("timeout, %0d results still expected", dist_expect_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> filelist.f
src/ssp_pkg.sv
src/ssp_ctrl.sv
src/ssp_datapath.sv
src/single_source_shortest_path.sv
dv/tb.sv
